// ===== sv/cbbf_pkg.sv =====
// cbbf_pkg: shared types, register indexes and constants for the content
// bounding box finder. No dependencies.
`timescale 1ns / 1ps

package cbbf_pkg;

    // largest supported frame side (pixels per row, rows per frame)
    localparam int MAX_SIDE_DEFAULT = 4096;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int SIZE_W      = 13;
    localparam int COLOR_W     = 8;
    localparam int COORD_W     = 12;
    localparam int DIM_W       = 13;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BG_RED       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BG_GREEN     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BG_BLUE      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE    = 3'd5;

    // reset values: white background, exact match, 1x1 frame
    localparam logic [COLOR_W-1:0] BG_RESET        = 8'hff;
    localparam logic [COLOR_W-1:0] TOLERANCE_RESET = 8'h00;
    localparam logic [SIZE_W-1:0]  SIDE_RESET      = 13'd1;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] alpha;
    } pixel_t;

    typedef struct packed {
        logic               found;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [DIM_W-1:0]   box_width;
        logic [DIM_W-1:0]   box_height;
    } box_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  image_width;
        logic [SIZE_W-1:0]  image_height;
        logic [COLOR_W-1:0] bg_red;
        logic [COLOR_W-1:0] bg_green;
        logic [COLOR_W-1:0] bg_blue;
        logic [COLOR_W-1:0] tolerance;
    } cfg_t;

    // classified pixel handed from the input stage to the tracker
    typedef struct packed {
        logic valid;
        logic content;
    } pix_stage_t;

    // absolute channel difference above tolerance
    function automatic logic differs(input logic [COLOR_W-1:0] a,
                                     input logic [COLOR_W-1:0] b,
                                     input logic [COLOR_W-1:0] tol);
        logic [COLOR_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return d > tol;
    endfunction

endpackage

// ===== sv/content_bounding_box_finder_core.sv =====
// content_bounding_box_finder_core: top level, configuration registers and
// the two pipeline parts. Depends on cbbf_pkg, cbbf_classify, cbbf_tracker.
`timescale 1ns / 1ps

// usage
//   s_ channel: one RGBA pixel word per handshake, frame in raster order
//   (row by row, left to right). m_ channel: one box word per frame, sent
//   after the last pixel of the frame; found low means no content pixel.
//   cfg channel: register index and data; always ready. Write frame size,
//   background color and tolerance only while no pixel is in flight.
// throughput
//   one pixel per cycle sustained while no pending box word holds a frame end. A pixel is
//   registered and classified at acceptance, and counted when the tracker takes
//   it; the box word goes through the result register to m_valid.
// reset (aresetn low, synchronous)
//   frame counters and extremes clear, no word pending; registers go to a
//   1x1 frame, white background and zero tolerance.
// receiver stall
//   the box word holds in the result register. Pixels keep flowing until the
//   next frame's last pixel reaches the tracker; that pixel waits in the
//   input register and s_ready drops until the pending word is taken.

module content_bounding_box_finder_core
    import cbbf_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // pixel input
    input  logic                   s_valid,
    output logic                   s_ready,
    input  pixel_t                 s_pixel,
    // box output
    output logic                   m_valid,
    input  logic                   m_ready,
    output box_t                   m_box,
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t       cfg_reg, cfg_next;
    pix_stage_t stage;
    logic       stage_ready;

    // register writes take effect at once
    assign cfg_ready = 1'b1;

    // register decode; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_next.image_width  = SIZE_W'(cfg_data);
                REG_IMAGE_HEIGHT: cfg_next.image_height = SIZE_W'(cfg_data);
                REG_BG_RED:       cfg_next.bg_red       = cfg_data[COLOR_W-1:0];
                REG_BG_GREEN:     cfg_next.bg_green     = cfg_data[COLOR_W-1:0];
                REG_BG_BLUE:      cfg_next.bg_blue      = cfg_data[COLOR_W-1:0];
                REG_TOLERANCE:    cfg_next.tolerance    = cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.image_width  <= SIDE_RESET;
            cfg_reg.image_height <= SIDE_RESET;
            cfg_reg.bg_red       <= BG_RESET;
            cfg_reg.bg_green     <= BG_RESET;
            cfg_reg.bg_blue      <= BG_RESET;
            cfg_reg.tolerance    <= TOLERANCE_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // input register and content test
    cbbf_classify u_classify (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_pixel     (s_pixel),
        .cfg         (cfg_reg),
        .stage       (stage),
        .stage_ready (stage_ready)
    );

    // position counters, extremes and result register
    cbbf_tracker #(
        .MAX_SIDE (MAX_SIDE)
    ) u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .stage       (stage),
        .stage_ready (stage_ready),
        .cfg         (cfg_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_box       (m_box)
    );

endmodule

// ===== sv/cbbf_classify.sv =====
// cbbf_classify: input register stage, flags a pixel as content on entry.
// Depends on cbbf_pkg.
`timescale 1ns / 1ps

module cbbf_classify
    import cbbf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  pixel_t     s_pixel,
    input  cfg_t       cfg,
    output pix_stage_t stage,
    input  logic       stage_ready
);

    logic valid_reg, valid_next;
    logic content_reg, content_next;

    assign s_ready = !valid_reg || stage_ready;

    always_comb begin
        valid_next   = s_ready ? s_valid : valid_reg;
        content_next = (s_pixel.alpha != '0) &&
                       (differs(s_pixel.red,   cfg.bg_red,   cfg.tolerance) ||
                        differs(s_pixel.green, cfg.bg_green, cfg.tolerance) ||
                        differs(s_pixel.blue,  cfg.bg_blue,  cfg.tolerance));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            content_reg <= content_next;
        end
    end

    assign stage.valid   = valid_reg;
    assign stage.content = content_reg;

endmodule

// ===== sv/cbbf_tracker.sv =====
// cbbf_tracker: raster position counters, min/max content tracking and the
// result register. Depends on cbbf_pkg.
`timescale 1ns / 1ps

module cbbf_tracker
    import cbbf_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  pix_stage_t stage,
    output logic       stage_ready,
    input  cfg_t       cfg,
    output logic       m_valid,
    input  logic       m_ready,
    output box_t       m_box
);

    localparam int CW = $clog2(MAX_SIDE);
    localparam int LW = (CW + 2 > SIZE_W + 1) ? CW + 2 : SIZE_W + 1;

    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;
    logic [CW-1:0] min_c_reg, min_c_next;
    logic [CW-1:0] max_c_reg, max_c_next;
    logic [CW-1:0] min_r_reg, min_r_next;
    logic [CW-1:0] max_r_reg, max_r_next;
    logic          any_reg, any_next;
    logic          m_valid_reg, m_valid_next;
    box_t          box_reg, box_next;

    logic [LW-1:0] width_lw, height_lw;
    logic          last_col, last_row, frame_end, advance;
    logic [CW-1:0] upd_min_c, upd_max_c, upd_min_r, upd_max_r;
    logic          upd_any;

    // zero reads as one, above MAX_SIDE reads as MAX_SIDE
    function automatic logic [LW-1:0] clamp_side(input logic [SIZE_W-1:0] v);
        logic [LW-1:0] x;
        x = LW'(v);
        if (x == '0)
            return LW'(1);
        if (x > LW'(MAX_SIDE))
            return LW'(MAX_SIDE);
        return x;
    endfunction

    always_comb begin
        width_lw  = clamp_side(cfg.image_width);
        height_lw = clamp_side(cfg.image_height);
        last_col  = (LW'(col_reg) + LW'(1)) >= width_lw;
        last_row  = (LW'(row_reg) + LW'(1)) >= height_lw;
        frame_end = last_col && last_row;
        advance   = stage.valid && (!frame_end || !m_valid_reg || m_ready);
        stage_ready = advance;

        upd_min_c = min_c_reg;
        upd_max_c = max_c_reg;
        upd_min_r = min_r_reg;
        upd_max_r = max_r_reg;
        upd_any   = any_reg;
        if (stage.content) begin
            if (!any_reg) begin
                upd_min_c = col_reg;
                upd_max_c = col_reg;
                upd_min_r = row_reg;
                upd_any   = 1'b1;
            end else begin
                if (col_reg < min_c_reg) upd_min_c = col_reg;
                if (col_reg > max_c_reg) upd_max_c = col_reg;
            end
            upd_max_r = row_reg;
        end

        col_next   = col_reg;
        row_next   = row_reg;
        min_c_next = min_c_reg;
        max_c_next = max_c_reg;
        min_r_next = min_r_reg;
        max_r_next = max_r_reg;
        any_next   = any_reg;
        box_next   = box_reg;
        m_valid_next = m_valid_reg && !m_ready;

        if (advance) begin
            min_c_next = upd_min_c;
            max_c_next = upd_max_c;
            min_r_next = upd_min_r;
            max_r_next = upd_max_r;
            any_next   = upd_any;
            if (!last_col) begin
                col_next = col_reg + CW'(1);
            end else begin
                col_next = '0;
                if (!last_row) begin
                    row_next = row_reg + CW'(1);
                end else begin
                    m_valid_next = 1'b1;
                    if (upd_any) begin
                        box_next.found      = 1'b1;
                        box_next.left       = COORD_W'(upd_min_c);
                        box_next.top        = COORD_W'(upd_min_r);
                        box_next.box_width  = DIM_W'(LW'(upd_max_c) + LW'(1) - LW'(upd_min_c));
                        box_next.box_height = DIM_W'(LW'(upd_max_r) + LW'(1) - LW'(upd_min_r));
                    end else begin
                        box_next = '0;
                    end
                    row_next   = '0;
                    min_c_next = '0;
                    max_c_next = '0;
                    min_r_next = '0;
                    max_r_next = '0;
                    any_next   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            min_c_reg   <= '0;
            max_c_reg   <= '0;
            min_r_reg   <= '0;
            max_r_reg   <= '0;
            any_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            min_c_reg   <= min_c_next;
            max_c_reg   <= max_c_next;
            min_r_reg   <= min_r_next;
            max_r_reg   <= max_r_next;
            any_reg     <= any_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload, no reset
    always_ff @(posedge aclk) begin
        box_reg <= box_next;
    end

    assign m_valid = m_valid_reg;
    assign m_box   = box_reg;

    // an empty frame reports an all-zero box
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !box_reg.found |->
            box_reg.left == '0 && box_reg.top == '0 &&
            box_reg.box_width == '0 && box_reg.box_height == '0)
        else $error("empty frame result carries nonzero box");

    // a found box always spans at least one pixel
    a_found_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && box_reg.found |->
            box_reg.box_width != '0 && box_reg.box_height != '0)
        else $error("found box with zero extent");

    // tracked extremes stay cleared until the first content pixel
    a_idle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !any_reg |-> min_c_reg == '0 && max_c_reg == '0 &&
                     min_r_reg == '0 && max_r_reg == '0)
        else $error("extremes set without content");

    // extremes stay ordered
    a_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        any_reg |-> min_c_reg <= max_c_reg && min_r_reg <= max_r_reg)
        else $error("min/max out of order");

    // a pending result is never overwritten by the next frame end
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(box_reg))
        else $error("result overwritten while stalled");

endmodule
